/* sv/pvsp_pkg.sv */
// ----------------------------------------------------------------------------
// pvsp_pkg
// shared types and constants for the polygon vertex store perimeter core
// ----------------------------------------------------------------------------
package pvsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int VERT_W       = 32;
    localparam int SQ_W         = 34;   // dx*dx + dy*dy, |d| <= 65535
    localparam int ROOT_W       = 17;
    localparam int PERIM_W      = 24;
    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PER_INIT,
        S_PER_RD,
        S_PER_NEXT,
        S_PER_DIFF,
        S_PER_MUL,
        S_PER_SQRT,
        S_PER_ACC,
        S_OUT
    } pvsp_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_item;   // latch request, do append/clear/count update
        logic shift_rd;    // read entry ptr+1
        logic shift_wr;    // write entry ptr, advance pointer
        logic shift_done;  // decrement count
        logic per_init;    // clear sum, pointer to 0
        logic per_next;    // latch current vertex, read next
        logic per_diff;    // coordinate differences
        logic sqrt_start;
        logic sqrt_step;
        logic per_acc;     // accumulate, advance pointer
    } pvsp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       remove_ok;
        logic       shift_last;
        logic       per_empty;
        logic       per_last;
        logic       sqrt_done;
    } pvsp_sts_t;

endpackage

/* sv/pvsp_ram.sv */
// ----------------------------------------------------------------------------
// pvsp_ram
// generic single write port, single registered read port ram
// ----------------------------------------------------------------------------
module pvsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/pvsp_datapath.sv */
// ----------------------------------------------------------------------------
// pvsp_datapath
// vertex ram, count, removal shift, edge length and perimeter sum
// ----------------------------------------------------------------------------
module pvsp_datapath import pvsp_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pvsp_cmd_t                 cmd,
    output pvsp_sts_t                 sts,
    input  logic [1:0]                s_operation,
    input  logic signed [15:0]        s_vertex_x,
    input  logic signed [15:0]        s_vertex_y,
    input  logic [5:0]                s_position,
    output logic [1:0]                res_status,
    output logic [COUNT_W-1:0]        res_count,
    output logic [PERIM_W-1:0]        res_perimeter
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [1:0]         status_reg;
    logic [COUNT_W-1:0] ptr_reg;
    logic [VERT_W-1:0]  va_reg;
    logic [16:0]        ax_reg, ay_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [4:0]         sq_iter_reg;
    logic [PERIM_W-1:0] sum_reg;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [VERT_W-1:0]  wr_data, rd_data;

    logic               remove_ok;
    logic               not_full;
    logic [COUNT_W-1:0] ptr_inc;
    logic [COUNT_W-1:0] nxt_idx;

    assign ptr_inc   = ptr_reg + COUNT_W'(1);
    assign nxt_idx   = (ptr_inc < count_reg) ? ptr_inc : '0;
    assign remove_ok = (COUNT_W'(s_position) < count_reg);
    assign not_full  = (count_reg < COUNT_W'(MAX_VERTICES));

    pvsp_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg[ADDR_W-1:0];
        wr_data = rd_data;
        rd_addr = ptr_reg[ADDR_W-1:0];
        if (cmd.take_item && s_operation == OP_APPEND && not_full) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = {s_vertex_y, s_vertex_x};
        end else if (cmd.shift_wr) begin
            wr_en = 1'b1;
        end
        if (cmd.shift_rd) begin
            rd_addr = ptr_inc[ADDR_W-1:0];
        end else if (cmd.per_next) begin
            rd_addr = nxt_idx[ADDR_W-1:0];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.take_item) begin
            case (s_operation)
                OP_APPEND: begin
                    if (not_full) count_next = count_reg + COUNT_W'(1);
                end
                OP_CLEAR:  count_next = '0;
                default:   count_next = count_reg;
            endcase
        end else if (cmd.shift_done) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // isqrt restoring step, two radicand bits in and one result bit out per step
    logic [SQ_W+1:0] trial;
    logic [SQ_W-1:0] pair;
    assign pair  = sq_reg;
    assign trial = {rem_reg, pair[SQ_W-1 -: 2]} - {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            case (s_operation)
                OP_APPEND: status_reg <= not_full ? ST_DONE : ST_FULL;
                OP_REMOVE: status_reg <= remove_ok ? ST_DONE : ST_BAD_POS;
                default:   status_reg <= ST_DONE;
            endcase
            ptr_reg <= COUNT_W'(s_position);
        end
        if (cmd.shift_wr) begin
            ptr_reg <= ptr_inc;
        end
        if (cmd.per_init) begin
            ptr_reg <= '0;
            sum_reg <= '0;
        end
        if (cmd.per_next) begin
            va_reg <= rd_data;
        end
        if (cmd.per_diff) begin
            ax_reg <= 17'($signed(va_reg[15:0]) - $signed(rd_data[15:0]));
            ay_reg <= 17'($signed(va_reg[31:16]) - $signed(rd_data[31:16]));
        end
        if (cmd.sqrt_start) begin
            sq_reg <= SQ_W'(($signed(ax_reg) * $signed(ax_reg)))
                    + SQ_W'(($signed(ay_reg) * $signed(ay_reg)));
            rem_reg     <= '0;
            root_reg    <= '0;
            sq_iter_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            sq_reg      <= {sq_reg[SQ_W-3:0], 2'b00};
            sq_iter_reg <= sq_iter_reg + 5'd1;
            if (!trial[SQ_W+1]) begin
                rem_reg  <= trial[SQ_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= {rem_reg[SQ_W-3:0], pair[SQ_W-1 -: 2]};
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.per_acc) begin
            ptr_reg <= ptr_inc;
            if ({1'b0, sum_reg} + (PERIM_W+1)'(root_reg) > (PERIM_W+1)'(PERIM_MAX))
                sum_reg <= PERIM_MAX;
            else
                sum_reg <= sum_reg + PERIM_W'(root_reg);
        end
    end

    assign sts.remove_ok  = remove_ok;
    assign sts.shift_last = (ptr_inc + COUNT_W'(1) >= count_reg);
    assign sts.per_empty  = (count_reg == '0);
    assign sts.per_last   = (ptr_inc >= count_reg);
    assign sts.sqrt_done  = (sq_iter_reg == 5'(SQ_W/2));

    assign res_status    = status_reg;
    assign res_count     = count_reg;
    assign res_perimeter = sum_reg;

endmodule

/* sv/pvsp_ctrl.sv */
// ----------------------------------------------------------------------------
// pvsp_ctrl
// sequencer for removal shift and perimeter pass
// ----------------------------------------------------------------------------
module pvsp_ctrl import pvsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    output logic        m_valid,
    input  logic        m_ready,
    output pvsp_cmd_t   cmd,
    input  pvsp_sts_t   sts
);

    pvsp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                if (s_operation == OP_REMOVE && sts.remove_ok)
                    state_next = S_SHIFT_RD;
                else
                    state_next = S_PER_INIT;
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: state_next = sts.shift_last ? S_PER_INIT : S_SHIFT_RD;
            S_PER_INIT: state_next = S_PER_RD;
            S_PER_RD:   state_next = sts.per_empty ? S_OUT : S_PER_NEXT;
            S_PER_NEXT: state_next = S_PER_DIFF;
            S_PER_DIFF: state_next = S_PER_MUL;
            S_PER_MUL:  state_next = S_PER_SQRT;
            S_PER_SQRT: if (sts.sqrt_done) state_next = S_PER_ACC;
            S_PER_ACC:  state_next = sts.per_last ? S_OUT : S_PER_RD;
            S_OUT:      if (m_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.take_item = s_valid;
            end
            S_SHIFT_RD: cmd.shift_rd = 1'b1;
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                cmd.shift_done = sts.shift_last;
            end
            S_PER_INIT: cmd.per_init = 1'b1;
            S_PER_NEXT: cmd.per_next = 1'b1;
            S_PER_DIFF: cmd.per_diff = 1'b1;
            S_PER_MUL:  cmd.sqrt_start = 1'b1;
            S_PER_SQRT: cmd.sqrt_step = !sts.sqrt_done;
            S_PER_ACC:  cmd.per_acc = 1'b1;
            S_OUT:      m_valid = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

/* sv/polygon_vertex_store_perimeter_core.sv */
// ----------------------------------------------------------------------------
// polygon_vertex_store_perimeter_core
// ordered vertex list with closed-loop perimeter after every request
// ----------------------------------------------------------------------------
// One request at a time. Append, clear and query go from acceptance straight
// to the perimeter pass, which an empty list skips; remove first shifts each
// vertex behind the removed one down a place (a read, then a write), with one
// such step even for the last vertex. Each edge costs two reads from the
// registered-read ram, a difference, a square and a restoring square root.
module polygon_vertex_store_perimeter_core import pvsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic [5:0]         s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [6:0]         m_vertex_count,
    output logic [23:0]        m_perimeter_length
);

    pvsp_cmd_t cmd;
    pvsp_sts_t sts;
    logic [COUNT_W-1:0] res_count;

    pvsp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    pvsp_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_operation   (s_operation),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_position    (s_position),
        .res_status    (m_status),
        .res_count     (res_count),
        .res_perimeter (m_perimeter_length)
    );

    assign m_vertex_count = 7'(res_count);

    // a finished request is held until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_perimeter_length))
        else $error("result changed while stalled");
    // no new request while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken during output");
    // vertex count never beyond capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_count <= COUNT_W'(MAX_VERTICES))
        else $error("count overflow");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the polygon vertex store perimeter core
// ----------------------------------------------------------------------------
// Requests are driven with valid/ready under several idle and stall mixes. A
// small scoreboard keeps its own vertex list, predicts status, count and
// closed-loop perimeter for every accepted request and checks each response
// in order against the oldest prediction.
module tb_top import pvsp_pkg::*; ();

    // scoreboard: shadow vertex list and queue of predicted responses
    class perimeter_scoreboard;
        logic [31:0] verts [MAX_VERTICES];
        int          held;
        logic [1:0]  exp_status [$];
        logic [6:0]  exp_count  [$];
        logic [23:0] exp_perim  [$];
        int          errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [23:0] loop_length();
            longint unsigned acc;
            longint dx;
            longint dy;
            int k;
            int nx;
            acc = 0;
            for (k = 0; k < held; k++) begin
                nx = (k + 1 < held) ? k + 1 : 0;
                dx = longint'($signed(verts[k][15:0])) - longint'($signed(verts[nx][15:0]));
                dy = longint'($signed(verts[k][31:16])) - longint'($signed(verts[nx][31:16]));
                acc += root_floor(dx * dx + dy * dy);
                if (acc > PERIM_MAX) acc = PERIM_MAX;
            end
            return acc[23:0];
        endfunction

        // note one accepted request
        function void take_request(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                   logic [5:0] pos);
            logic [1:0] st;
            int k;
            st = ST_DONE;
            case (op)
                OP_APPEND: begin
                    if (held >= MAX_VERTICES) st = ST_FULL;
                    else begin
                        verts[held] = {y, x};
                        held++;
                    end
                end
                OP_REMOVE: begin
                    if (pos >= held) st = ST_BAD_POS;
                    else begin
                        for (k = pos; k + 1 < held; k++) verts[k] = verts[k + 1];
                        held--;
                    end
                end
                OP_CLEAR: held = 0;
                default: ;
            endcase
            exp_status.push_back(st);
            exp_count.push_back(held[6:0]);
            exp_perim.push_back(loop_length());
        endfunction

        // compare one response with the oldest prediction
        function void check_response(logic [1:0] st, logic [6:0] cnt, logic [23:0] per);
            logic [1:0]  es;
            logic [6:0]  ec;
            logic [23:0] ep;
            if (exp_status.size() == 0) begin
                $display("%0t: unexpected response status %0d count %0d perimeter %0d",
                         $time, st, cnt, per);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ec = exp_count.pop_front();
            ep = exp_perim.pop_front();
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (cnt !== ec) begin
                $display("%0t: count expected %0d actual %0d", $time, ec, cnt);
                errors++;
            end
            if (per !== ep) begin
                $display("%0t: perimeter expected %0d actual %0d", $time, ep, per);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic signed [15:0] s_vertex_x;
    logic signed [15:0] s_vertex_y;
    logic [5:0]  s_position;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [6:0]  m_vertex_count;
    logic [23:0] m_perimeter_length;

    perimeter_scoreboard sb;
    int send_idle_pct;   // chance of a gap before each request
    int recv_stall_pct;  // chance of holding ready low
    int quiet_cycles;

    polygon_vertex_store_perimeter_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y), .s_position(s_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_vertex_count(m_vertex_count), .m_perimeter_length(m_perimeter_length)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // response side: random stalls, checking at the accepting edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_response(m_status, m_vertex_count, m_perimeter_length);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with no request and no response accepted
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("polygon_vertex_store_perimeter_core regression: fail");
                $finish;
            end
        end
    end

    // drive one request and hold it until accepted
    task automatic send_request(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                logic [5:0] pos);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_vertex_x  <= x;
        s_vertex_y  <= y;
        s_position  <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_request(op, x, y, pos);
    endtask

    // random request, mostly appends and removes inside the list
    task automatic random_request();
        int pick;
        logic [5:0] pos;
        pick = $urandom_range(99);
        pos  = (sb.held > 0 && $urandom_range(3) != 0) ?
               6'($urandom_range(sb.held - 1)) : 6'($urandom);
        if (pick < 55)      send_request(OP_APPEND, 16'($urandom), 16'($urandom), 6'($urandom));
        else if (pick < 85) send_request(OP_REMOVE, 16'($urandom), 16'($urandom), pos);
        else if (pick < 90) send_request(OP_CLEAR, 16'($urandom), 16'($urandom), pos);
        else                send_request(OP_QUERY, 16'($urandom), 16'($urandom), pos);
    endtask

    initial begin
        int k;
        int ph;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_QUERY;
        s_vertex_x     = '0;
        s_vertex_y     = '0;
        s_position     = '0;
        m_ready        = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, single vertex, two vertices, extremes
        send_request(OP_QUERY, 16'h0, 16'h0, 6'd0);
        send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0);
        send_request(OP_APPEND, 16'h8000, 16'h8000, 6'd63);
        send_request(OP_REMOVE, 16'h0, 16'h0, 6'd1);
        send_request(OP_APPEND, 16'h7fff, 16'h7fff, 6'd0);
        send_request(OP_APPEND, 16'h8000, 16'h7fff, 6'd0);
        send_request(OP_APPEND, 16'h7fff, 16'h8000, 6'd0);
        send_request(OP_REMOVE, 16'hffff, 16'hffff, 6'd1);
        send_request(OP_REMOVE, 16'h0, 16'h0, 6'd63);
        send_request(OP_CLEAR, 16'h1234, 16'h5678, 6'd5);
        // fill the store past full, then remove at the ends
        for (k = 0; k < MAX_VERTICES + 2; k++)
            send_request(OP_APPEND, 16'($urandom), 16'($urandom), 6'($urandom));
        send_request(OP_REMOVE, 16'h0, 16'h0, 6'd63);
        send_request(OP_REMOVE, 16'h0, 16'h0, 6'd0);
        send_request(OP_QUERY, 16'hffff, 16'hffff, 6'd63);
        send_request(OP_CLEAR, 16'h0, 16'h0, 6'd0);

        // random phases over the idle and stall mixes
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 26 : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 26 : 0;
            for (k = 0; k < 93; k++) random_request();
        end
        s_valid <= 1'b0;

        while (sb.exp_status.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0)
            $display("polygon_vertex_store_perimeter_core regression: pass");
        else
            $display("polygon_vertex_store_perimeter_core regression: fail");
        $finish;
    end
endmodule
